// ----- rtl/sorted_array_edge_search_top_defines.svh -----
// assertion macros for the sorted array edge search block
// used by sorted_array_edge_search_top only, no other dependencies
`ifndef SORTED_ARRAY_EDGE_SEARCH_TOP_DEFINES_SVH
`define SORTED_ARRAY_EDGE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SAES_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("saes same-cycle check failed");

// next-cycle implication, checked outside reset
`define SAES_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("saes next-cycle check failed");

`endif

// ----- rtl/saes_pkg.sv -----
// shared constants, codes and types for the sorted array edge search block
// no dependencies
`default_nettype none

package saes_pkg;

    localparam int unsigned DEPTH  = 1024;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned POS_W  = $clog2(DEPTH + 1);
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 11;
    localparam int unsigned OP_W   = 2;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_CHECK  = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr;
        logic start;
        logic strict;
        logic step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic done;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/saes_if.sv -----
// request and response channel interfaces of the sorted array edge search block
// depends on saes_pkg for field widths
`default_nettype none

interface saes_req_if;
    logic                                valid;
    logic                                ready;
    logic [saes_pkg::OP_W-1:0]           op;
    logic [saes_pkg::ADDR_W-1:0]         write_slot;
    logic signed [saes_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output write_slot, output value, input ready);
    modport sink   (input valid, input op, input write_slot, input value, output ready);
endinterface

interface saes_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [saes_pkg::ADDR_W-1:0]         edge_index;
    logic [saes_pkg::POS_W-1:0]          insert_pos;

    modport source (output valid, output found, output edge_index, output insert_pos,
                    input ready);
    modport sink   (input valid, input found, input edge_index, input insert_pos,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/saes_datapath.sv -----
// datapath: value memory, search bounds, probe compare and result registers
// depends on saes_pkg
`default_nettype none

module saes_datapath (
    input  wire logic                                i_clk,
    input  wire saes_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [saes_pkg::ADDR_W-1:0]         i_write_slot,
    input  wire logic signed [saes_pkg::DATA_W-1:0]  i_value,
    input  wire logic [saes_pkg::CFG_W-1:0]          i_count_in_use,
    output saes_pkg::t_dp_stat                       o_stat,
    output logic                                     o_found,
    output logic [saes_pkg::ADDR_W-1:0]              o_edge_index,
    output logic [saes_pkg::POS_W-1:0]               o_insert_pos
);

    // value memory, one write and one registered read per cycle
    logic signed [saes_pkg::DATA_W-1:0] mem [saes_pkg::DEPTH];

    logic signed [saes_pkg::DATA_W-1:0] r_rdata;
    logic signed [saes_pkg::DATA_W-1:0] r_key;
    logic                               r_strict;
    logic [saes_pkg::POS_W-1:0]         r_lo;
    logic [saes_pkg::POS_W-1:0]         r_hi;
    logic [saes_pkg::POS_W-1:0]         r_n;
    logic [saes_pkg::ADDR_W-1:0]        r_mid;
    logic                               r_found;
    logic [saes_pkg::ADDR_W-1:0]        r_edge_index;
    logic [saes_pkg::POS_W-1:0]         r_insert_pos;

    logic [saes_pkg::POS_W-1:0]         n_lo;
    logic [saes_pkg::POS_W-1:0]         n_hi;
    logic [saes_pkg::ADDR_W-1:0]        n_raddr;
    logic [saes_pkg::POS_W-1:0]         active_n;
    logic [saes_pkg::POS_W-1:0]         chk_pos;
    logic [saes_pkg::POS_W-1:0]         edge_pos;
    logic                               strict_sel;
    logic                               go_right;
    logic                               search_on;
    logic                               hit;

    // probe point lo + (hi - 1 - lo) / 2, valid while lo < hi
    function automatic logic [saes_pkg::ADDR_W-1:0] mid_of(
        input logic [saes_pkg::POS_W-1:0] lo,
        input logic [saes_pkg::POS_W-1:0] hi
    );
        logic [saes_pkg::POS_W-1:0] span;
        logic [saes_pkg::POS_W-1:0] mid;
        span = hi - lo - saes_pkg::POS_W'(1);
        mid  = lo + (span >> 1);
        return mid[saes_pkg::ADDR_W-1:0];
    endfunction

    // entries in use, saturated at the depth
    always_comb begin
        if (i_count_in_use > saes_pkg::CFG_W'(saes_pkg::DEPTH)) begin
            active_n = saes_pkg::POS_W'(saes_pkg::DEPTH);
        end else begin
            active_n = saes_pkg::POS_W'(i_count_in_use);
        end
    end

    // bound update and next read address
    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        go_right = r_strict ? (r_rdata <= r_key) : (r_rdata < r_key);
        if (i_cmd.start) begin
            n_lo = '0;
            n_hi = active_n;
        end else if (i_cmd.step) begin
            if (go_right) begin
                n_lo = saes_pkg::POS_W'(r_mid) + saes_pkg::POS_W'(1);
            end else begin
                n_hi = saes_pkg::POS_W'(r_mid);
            end
        end
        strict_sel = i_cmd.start ? i_cmd.strict : r_strict;
        search_on  = n_lo < n_hi;
        // once the range is empty, fetch the entry at the edge
        chk_pos    = strict_sel ? (n_lo - saes_pkg::POS_W'(1)) : n_lo;
        n_raddr    = search_on ? mid_of(n_lo, n_hi) : chk_pos[saes_pkg::ADDR_W-1:0];
    end

    assign o_stat.done  = !search_on;
    assign o_stat.empty = (active_n == '0);

    // final edge check on the fetched entry
    always_comb begin
        hit      = (r_rdata == r_key) && (r_strict ? (r_lo != '0) : (r_lo < r_n));
        edge_pos = r_strict ? (r_lo - saes_pkg::POS_W'(1)) : r_lo;
    end

    // memory write and read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_write_slot] <= i_value;
        end
        if (i_cmd.start || i_cmd.step) begin
            r_rdata <= mem[n_raddr];
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start || i_cmd.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_raddr;
        end
        if (i_cmd.start) begin
            r_key    <= i_value;
            r_strict <= i_cmd.strict;
            r_n      <= active_n;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found      <= hit;
            r_edge_index <= hit ? edge_pos[saes_pkg::ADDR_W-1:0] : '0;
            r_insert_pos <= r_lo;
        end
    end

    assign o_found      = r_found;
    assign o_edge_index = r_edge_index;
    assign o_insert_pos = r_insert_pos;

endmodule

`default_nettype wire

// ----- rtl/saes_ctrl.sv -----
// controller: request decode, search sequencing and response valid
// depends on saes_pkg
`default_nettype none

module saes_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [saes_pkg::OP_W-1:0]   i_op,
    input  wire logic                        i_out_ready,
    input  wire saes_pkg::t_dp_stat          i_stat,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    output saes_pkg::t_dp_cmd                o_cmd
);

    saes_pkg::t_state r_state;
    saes_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    saes_pkg::t_op    req_op;

    assign req_op = saes_pkg::t_op'(i_op);

    // state and response valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saes_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            saes_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (req_op) inside
                        saes_pkg::OP_WRITE: begin
                            o_cmd.wr = 1'b1;
                        end
                        saes_pkg::OP_LEFT, saes_pkg::OP_RIGHT: begin
                            o_cmd.start  = 1'b1;
                            o_cmd.strict = (req_op == saes_pkg::OP_RIGHT);
                            n_state      = (i_stat.empty || i_stat.done)
                                           ? saes_pkg::ST_CHECK : saes_pkg::ST_SEARCH;
                        end
                        default: begin
                            // unused code, request dropped
                        end
                    endcase
                end
            end
            saes_pkg::ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.done) begin
                    n_state = saes_pkg::ST_CHECK;
                end
            end
            saes_pkg::ST_CHECK: begin
                // wait for the response register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = saes_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = saes_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/sorted_array_edge_search_top.sv -----
// Sorted array edge search, top level.
// Requests arrive on i_req (valid/ready). op 0 writes value into
// write_slot; op 1 finds the leftmost and op 2 the rightmost entry equal
// to the key, along with the lower or upper bound as insert_pos.
// Each query answers with one response on o_rsp; writes and unused op codes
// give none. i_cfg_we with i_cfg_wdata sets count_in_use, the number of
// leading entries searched (values above the depth act as the depth).
// A query binary-searches the value memory, one probe per cycle through its
// single registered read port: an accept step that issues the first read,
// probe steps in the search state while the range is non-empty (none for an
// empty array) and a check step. The response is visible the cycle after the
// check and the next request is taken in that same cycle. Requests are taken
// one at a time. When the receiver stalls, the response register holds its
// response and a following query waits in its check state until freed.
// Synchronous active-low reset returns to idle with no response pending and
// count_in_use cleared; memory contents are undefined until written.
// depends on saes_pkg, saes_if, saes_ctrl, saes_datapath and the defines header
`default_nettype none

`include "sorted_array_edge_search_top_defines.svh"

module sorted_array_edge_search_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    saes_req_if.sink                         i_req,
    saes_rsp_if.source                       o_rsp,
    input  wire logic                        i_cfg_we,
    input  wire logic [saes_pkg::CFG_W-1:0]  i_cfg_wdata
);

    logic [saes_pkg::CFG_W-1:0] r_count_in_use;
    saes_pkg::t_dp_cmd          dp_cmd;
    saes_pkg::t_dp_stat         dp_stat;
    logic                       req_ready;
    logic                       query_take;
    logic                       rsp_miss;
    logic                       rsp_hit;
    logic                       edge_at_pos;

    // count_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_in_use <= '0;
        end else if (i_cfg_we) begin
            r_count_in_use <= i_cfg_wdata;
        end
    end

    saes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_op        (i_req.op),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (req_ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    saes_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_write_slot   (i_req.write_slot),
        .i_value        (i_req.value),
        .i_count_in_use (r_count_in_use),
        .o_stat         (dp_stat),
        .o_found        (o_rsp.found),
        .o_edge_index   (o_rsp.edge_index),
        .o_insert_pos   (o_rsp.insert_pos)
    );

    assign i_req.ready = req_ready;

    // terms for the checks below
    assign query_take  = i_req.valid && req_ready
                         && (i_req.op == saes_pkg::OP_LEFT || i_req.op == saes_pkg::OP_RIGHT);
    assign rsp_miss    = o_rsp.valid && !o_rsp.found;
    assign rsp_hit     = o_rsp.valid && o_rsp.found;
    assign edge_at_pos = (saes_pkg::POS_W'(o_rsp.edge_index) == o_rsp.insert_pos)
                         || (saes_pkg::POS_W'(o_rsp.edge_index) + saes_pkg::POS_W'(1)
                             == o_rsp.insert_pos);

    // a query blocks further requests while it searches
    `SAES_ASSERT_NEXT(a_query_blocks, i_clk, i_rst_n, query_take, !req_ready)

    // a miss reports edge index zero
    `SAES_ASSERT_NOW(a_miss_edge_zero, i_clk, i_rst_n, rsp_miss, o_rsp.edge_index == '0)

    // a hit edge sits at the bound or just below it
    `SAES_ASSERT_NOW(a_hit_edge_near_pos, i_clk, i_rst_n, rsp_hit, edge_at_pos)

endmodule

`default_nettype wire
